[sv/mrsc_pkg.sv]
// ----------------------------------------------------------------------------
// mrsc_pkg
// Shared widths, types and helper functions for the modular-range stream
// cipher core.
// ----------------------------------------------------------------------------
package mrsc_pkg;

  // Coefficient and keystream widths
  localparam int COEF_WIDTH = 16;
  localparam int KS_WIDTH   = 16;

  // A remainder is below the range size, which reaches 2^COEF_WIDTH
  localparam int REM_WIDTH = COEF_WIDTH + 1;

  // Modulo pipeline: MOD_STEPS restoring steps per stage
  localparam int DVD_MAX     = (COEF_WIDTH > KS_WIDTH) ? COEF_WIDTH : KS_WIDTH;
  localparam int MOD_STEPS   = 4;
  localparam int MOD_STAGES  = (DVD_MAX + MOD_STEPS - 1) / MOD_STEPS;
  localparam int DVD_WIDTH   = MOD_STAGES * MOD_STEPS;
  localparam int PIPE_STAGES = MOD_STAGES + 2;

  localparam int CFG_IDX_WIDTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_RANGE_MIN = 2'd0,
    CFG_RANGE_MAX = 2'd1,
    CFG_DIRECTION = 2'd2,
    CFG_SKIP_ZERO = 2'd3
  } cfg_reg_e;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic [REM_WIDTH-1:0]         rem_t;
  typedef logic [DVD_WIDTH-1:0]         dvd_t;

  localparam coef_t RANGE_MIN_RST = coef_t'(-1024);
  localparam coef_t RANGE_MAX_RST = coef_t'(1023);

  // Configuration as seen by the datapath
  typedef struct packed {
    coef_t range_min;
    coef_t range_max;
    rem_t  range_size;
    logic  direction;
    logic  skip_zero;
  } cfg_t;

  // Item travelling through the modulo pipeline: two lanes reduced in step
  typedef struct packed {
    coef_t coef;
    logic  last;
    logic  err;
    dvd_t  off_dvd;
    rem_t  off_rem;
    dvd_t  ks_dvd;
    rem_t  ks_rem;
  } pipe_t;

  // Range size max - min + 1; meaningful only when max >= min
  function automatic rem_t range_size(coef_t lo, coef_t hi);
    logic signed [COEF_WIDTH:0] diff;
    diff = {hi[COEF_WIDTH-1], hi} - {lo[COEF_WIDTH-1], lo};
    return diff[REM_WIDTH-1:0] + {{(REM_WIDTH-1){1'b0}}, 1'b1};
  endfunction

  // One restoring step: shift in a dividend bit, subtract divisor if it fits
  function automatic rem_t mod_step(rem_t rem, logic bit_in, rem_t divisor);
    logic [REM_WIDTH:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, divisor}) begin
      t = t - {1'b0, divisor};
    end
    return t[REM_WIDTH-1:0];
  endfunction

endpackage

[sv/mrsc_front.sv]
// ----------------------------------------------------------------------------
// mrsc_front
// Entry stage: forms the offset from range_min, flags an empty range and
// loads both modulo lanes.
// ----------------------------------------------------------------------------
module mrsc_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  mrsc_pkg::cfg_t                      cfg_i,
  input  logic signed [mrsc_pkg::COEF_WIDTH-1:0] coefficient_i,
  input  logic [mrsc_pkg::KS_WIDTH-1:0]       keystream_word_i,
  input  logic                                block_last_in_i,
  output mrsc_pkg::pipe_t                     pipe_o
);

  logic [mrsc_pkg::COEF_WIDTH-1:0] offset;
  mrsc_pkg::pipe_t                 pipe_d, pipe_q;

  // Offset wraps modulo 2^COEF_WIDTH
  assign offset = coefficient_i - cfg_i.range_min;

  always_comb begin
    pipe_d         = '0;
    pipe_d.coef    = coefficient_i;
    pipe_d.last    = block_last_in_i;
    pipe_d.err     = $signed(cfg_i.range_max) < $signed(cfg_i.range_min);
    pipe_d.off_dvd = mrsc_pkg::DVD_WIDTH'(offset);
    pipe_d.off_rem = '0;
    pipe_d.ks_dvd  = mrsc_pkg::DVD_WIDTH'(keystream_word_i);
    pipe_d.ks_rem  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

[sv/mrsc_mod_stage.sv]
// ----------------------------------------------------------------------------
// mrsc_mod_stage
// One stage of the pipelined modulo unit: MOD_STEPS restoring steps on the
// offset lane and the keystream lane.
// ----------------------------------------------------------------------------
module mrsc_mod_stage (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  mrsc_pkg::rem_t       range_size_i,
  input  mrsc_pkg::pipe_t      pipe_i,
  output mrsc_pkg::pipe_t      pipe_o
);

  localparam int DW = mrsc_pkg::DVD_WIDTH;

  mrsc_pkg::pipe_t pipe_d, pipe_q;

  // Consume dividend bits MSB first
  always_comb begin
    pipe_d = pipe_i;
    for (int j = 0; j < mrsc_pkg::MOD_STEPS; j++) begin
      pipe_d.off_rem = mrsc_pkg::mod_step(pipe_d.off_rem, pipe_d.off_dvd[DW-1],
                                          range_size_i);
      pipe_d.ks_rem  = mrsc_pkg::mod_step(pipe_d.ks_rem, pipe_d.ks_dvd[DW-1],
                                          range_size_i);
      pipe_d.off_dvd = {pipe_d.off_dvd[DW-2:0], 1'b0};
      pipe_d.ks_dvd  = {pipe_d.ks_dvd[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

[sv/mrsc_back.sv]
// ----------------------------------------------------------------------------
// mrsc_back
// Final stage and output register: modular add of the two remainders,
// mapping back into the range and the skip-zero / error selection.
// ----------------------------------------------------------------------------
module mrsc_back (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  mrsc_pkg::cfg_t                         cfg_i,
  input  mrsc_pkg::pipe_t                        pipe_i,
  output logic signed [mrsc_pkg::COEF_WIDTH-1:0] result_coefficient_o,
  output logic                                   range_error_o,
  output logic                                   block_last_out_o
);

  localparam int CW = mrsc_pkg::COEF_WIDTH;
  localparam int RW = mrsc_pkg::REM_WIDTH;

  mrsc_pkg::rem_t  addend;
  logic [RW:0]     sum;
  logic [CW-1:0]   mapped;
  mrsc_pkg::coef_t result_d, result_q;
  logic            err_q, last_q;

  // Encrypt adds d, decrypt adds r - d; both sums stay below 2r
  always_comb begin
    addend = cfg_i.direction ? (cfg_i.range_size - pipe_i.ks_rem) : pipe_i.ks_rem;
    sum    = {1'b0, pipe_i.off_rem} + {1'b0, addend};
    if (sum >= {1'b0, cfg_i.range_size}) begin
      sum = sum - {1'b0, cfg_i.range_size};
    end
    mapped = sum[CW-1:0] + cfg_i.range_min;
  end

  // Result selection
  always_comb begin
    result_d = pipe_i.coef;
    if (pipe_i.err) begin
      result_d = pipe_i.coef;
    end else if (!cfg_i.direction) begin
      if (!cfg_i.skip_zero || (pipe_i.coef != '0 && mapped != '0)) begin
        result_d = mapped;
      end
    end else if (cfg_i.range_size == {{(RW-1){1'b0}}, 1'b1}) begin
      result_d = cfg_i.range_min;
    end else if (!(cfg_i.skip_zero && pipe_i.coef == '0)) begin
      result_d = mapped;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
      err_q    <= pipe_i.err;
      last_q   <= pipe_i.last;
    end
  end

  assign result_coefficient_o = result_q;
  assign range_error_o        = err_q;
  assign block_last_out_o     = last_q;

endmodule

[sv/modular_range_stream_cipher_core.sv]
// ----------------------------------------------------------------------------
// modular_range_stream_cipher_core
// Format-preserving modular-addition cipher over a configured value range.
// ----------------------------------------------------------------------------
// Pipeline from input transfer to output valid: one entry stage, MOD_STAGES
// modulo stages, one output stage.
// Throughput: one item per cycle; the modulo unit is fully pipelined and each
// stage stalls only when the stage after it is full and not moving.
// Reset: asynchronous, active low; clears all valid bits and loads the
// configuration defaults (range -1024..1023, encrypt, skip-zero off).
module modular_range_stream_cipher_core (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration write port
  input  logic                                       cfg_we_i,
  input  logic [mrsc_pkg::CFG_IDX_WIDTH-1:0]         cfg_index_i,
  input  logic [mrsc_pkg::COEF_WIDTH-1:0]            cfg_data_i,
  // input channel
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [mrsc_pkg::COEF_WIDTH-1:0]     coefficient_i,
  input  logic [mrsc_pkg::KS_WIDTH-1:0]              keystream_word_i,
  input  logic                                       block_last_in_i,
  // output channel
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [mrsc_pkg::COEF_WIDTH-1:0]     result_coefficient_o,
  output logic                                       range_error_o,
  output logic                                       block_last_out_o
);

  localparam int NS = mrsc_pkg::PIPE_STAGES;
  localparam int NM = mrsc_pkg::MOD_STAGES;

  mrsc_pkg::coef_t range_min_q, range_max_q;
  mrsc_pkg::rem_t  range_size_q;
  logic            direction_q, skip_zero_q;
  mrsc_pkg::cfg_t  cfg;

  logic [NS-1:0]   v_d, v_q;
  logic [NS:0]     rdy;
  mrsc_pkg::pipe_t pipe_s [NM+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= mrsc_pkg::RANGE_MIN_RST;
      range_max_q <= mrsc_pkg::RANGE_MAX_RST;
      direction_q <= 1'b0;
      skip_zero_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (mrsc_pkg::cfg_reg_e'(cfg_index_i))
        mrsc_pkg::CFG_RANGE_MIN: range_min_q <= cfg_data_i;
        mrsc_pkg::CFG_RANGE_MAX: range_max_q <= cfg_data_i;
        mrsc_pkg::CFG_DIRECTION: direction_q <= cfg_data_i[0];
        mrsc_pkg::CFG_SKIP_ZERO: skip_zero_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Range size, registered off the config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_size_q <= mrsc_pkg::range_size(mrsc_pkg::RANGE_MIN_RST,
                                           mrsc_pkg::RANGE_MAX_RST);
    end else begin
      range_size_q <= mrsc_pkg::range_size(range_min_q, range_max_q);
    end
  end

  always_comb begin
    cfg.range_min  = range_min_q;
    cfg.range_max  = range_max_q;
    cfg.range_size = range_size_q;
    cfg.direction  = direction_q;
    cfg.skip_zero  = skip_zero_q;
  end

  // Per-stage flow control: a stage loads when empty or when it drains
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (rdy[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  // Entry stage
  mrsc_front u_front (
    .clk_i            (clk_i),
    .en_i             (rdy[0]),
    .cfg_i            (cfg),
    .coefficient_i    (coefficient_i),
    .keystream_word_i (keystream_word_i),
    .block_last_in_i  (block_last_in_i),
    .pipe_o           (pipe_s[0])
  );

  // Modulo pipeline
  for (genvar g = 0; g < NM; g++) begin : g_mod
    mrsc_mod_stage u_mod_stage (
      .clk_i        (clk_i),
      .en_i         (rdy[g+1]),
      .range_size_i (range_size_q),
      .pipe_i       (pipe_s[g]),
      .pipe_o       (pipe_s[g+1])
    );
  end

  // Output stage
  mrsc_back u_back (
    .clk_i                (clk_i),
    .en_i                 (rdy[NS-1]),
    .cfg_i                (cfg),
    .pipe_i               (pipe_s[NM]),
    .result_coefficient_o (result_coefficient_o),
    .range_error_o        (range_error_o),
    .block_last_out_o     (block_last_out_o)
  );

  // Assertions
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> in_ready_o)
    else $error("input not ready while output stage is empty");

  a_backpressure_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&v_q) && !out_ready_i))
    else $error("input stalled with a bubble in the pipeline");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) == $past($countones(v_q))
                       + ($past(in_valid_i && in_ready_o) ? 1 : 0)
                       - ($past(out_valid_o && out_ready_i) ? 1 : 0)))
    else $error("item lost or duplicated in the pipeline");

  a_entry_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !rdy[0]) |=> (v_q[0] && $stable(pipe_s[0])))
    else $error("stalled entry stage changed");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_range_stream_cipher_core. A built-in
// predictor computes each cipher result from a shadow copy of the range,
// direction and skip-zero settings. Results are compared in order as they
// transfer out. The run covers directed corner cases first, then random
// streams under many range settings, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW              = mrsc_pkg::COEF_WIDTH;
  localparam int KW              = mrsc_pkg::KS_WIDTH;
  localparam int RESET_CYCLES    = 8;
  localparam int LATENCY         = mrsc_pkg::MOD_STAGES + 1;
  localparam int SETTLE_CYCLES   = 4 * LATENCY;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int PRINT_LIMIT     = 100;
  localparam longint COEF_MASK   = (64'sd1 << CW) - 1;

  typedef struct packed {
    mrsc_pkg::coef_t coef;
    logic            err;
    logic            last;
  } cipher_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                                cfg_we;
  logic [mrsc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CW-1:0]                       cfg_data;

  logic            in_valid;
  logic            in_ready;
  mrsc_pkg::coef_t coefficient;
  logic [KW-1:0]   keystream;
  logic            last_in;

  logic            out_valid;
  logic            out_ready;
  mrsc_pkg::coef_t result_coef;
  logic            range_err;
  logic            last_out;

  // shadow of the block's configuration
  mrsc_pkg::coef_t shadow_min     = mrsc_pkg::RANGE_MIN_RST;
  mrsc_pkg::coef_t shadow_max     = mrsc_pkg::RANGE_MAX_RST;
  logic            shadow_decrypt = 1'b0;
  logic            shadow_skip    = 1'b0;

  cipher_result_t expected_cipher_q[$];

  int cycle_count     = 0;
  int mismatch_count  = 0;
  int coefs_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int empty_range_hits = 0;
  int block_ends      = 0;
  int burst_left      = 0;

  always #1 clk_i = ~clk_i;

  modular_range_stream_cipher_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .coefficient_i       (coefficient),
    .keystream_word_i    (keystream),
    .block_last_in_i     (last_in),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .result_coefficient_o(result_coef),
    .range_error_o       (range_err),
    .block_last_out_o    (last_out)
  );

  // Expected cipher output for one coefficient under the shadow settings
  function automatic cipher_result_t cipher_predict(mrsc_pkg::coef_t coef, logic [KW-1:0] ks,
                                                    logic last);
    cipher_result_t r;
    longint lo, hi, span, offset, shift, sum;
    mrsc_pkg::coef_t mapped;
    r.coef = coef;
    r.err  = 1'b0;
    r.last = last;
    lo = longint'(shadow_min);
    hi = longint'(shadow_max);
    if (hi < lo) begin
      r.err = 1'b1;
    end else begin
      span   = hi - lo + 1;
      offset = (longint'(coef) - lo) & COEF_MASK;
      shift  = longint'(ks) % span;
      if (!shadow_decrypt) begin
        sum    = (offset + shift) % span;
        mapped = mrsc_pkg::coef_t'(sum + lo);
        // skip-zero: keep zeros and never produce one
        if (!shadow_skip || (coef != 0 && mapped != 0)) begin
          r.coef = mapped;
        end
      end else if (span == 1) begin
        // one-value range maps everything to min, zero included
        r.coef = mrsc_pkg::coef_t'(lo);
      end else begin
        sum    = (offset + span - shift) % span;
        mapped = mrsc_pkg::coef_t'(sum + lo);
        if (!(shadow_skip && coef == 0)) begin
          r.coef = mapped;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("MISMATCH at result %0d: %s got %0d, want %0d", results_checked, what, got,
               want);
    end
    mismatch_count++;
  endtask

  // Result checker: every output transfer against the oldest prediction
  always @(posedge clk_i) begin : check_results
    cipher_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_cipher_q.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(result_coef), 64'sd0);
      end else begin
        want = expected_cipher_q.pop_front();
        if (result_coef !== want.coef) begin
          report_mismatch("result_coefficient", longint'(result_coef), longint'(want.coef));
        end
        if (range_err !== want.err) begin
          report_mismatch("range_error", longint'(range_err), longint'(want.err));
        end
        if (last_out !== want.last) begin
          report_mismatch("block_last_out", longint'(last_out), longint'(want.last));
        end
        if (want.err) empty_range_hits++;
        if (want.last) block_ends++;
      end
      results_checked++;
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_cipher_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sink: ready pattern switches between free-running, light, heavy and periodic stalls
  initial begin : sink_stall
    int mode;
    int left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((left % 8) < 3);
      endcase
    end
  end

  // One input transfer; source idles in bursts. Returns at a falling edge with valid high.
  task automatic send_coef(mrsc_pkg::coef_t coef, logic [KW-1:0] ks, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    coefficient <= coef;
    keystream   <= ks;
    last_in     <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_cipher_q.push_back(cipher_predict(coef, ks, last));
    coefs_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Stop the source and wait for every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (expected_cipher_q.size() != 0);
  endtask

  task automatic write_reg(mrsc_pkg::cfg_reg_e idx, mrsc_pkg::coef_t value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      mrsc_pkg::CFG_RANGE_MIN: shadow_min = value;
      mrsc_pkg::CFG_RANGE_MAX: shadow_max = value;
      mrsc_pkg::CFG_DIRECTION: shadow_decrypt = value[0];
      default:                 shadow_skip = value[0];
    endcase
  endtask

  // Flag registers get random upper bits, which the block must ignore
  task automatic set_config(mrsc_pkg::coef_t lo, mrsc_pkg::coef_t hi, logic decrypt,
                            logic skip);
    mrsc_pkg::coef_t noise;
    noise = mrsc_pkg::coef_t'($urandom);
    write_reg(mrsc_pkg::CFG_RANGE_MIN, lo);
    write_reg(mrsc_pkg::CFG_RANGE_MAX, hi);
    write_reg(mrsc_pkg::CFG_DIRECTION, {noise[CW-1:1], decrypt});
    write_reg(mrsc_pkg::CFG_SKIP_ZERO, {noise[CW-2:0], skip});
    settings_used++;
  endtask

  // Reset settings: range -1024..1023, encrypt
  task automatic test_reset_settings();
    send_coef(-16'sd1024, 16'h0000, 1'b0);
    send_coef(16'sd1023, 16'h0001, 1'b0);
    send_coef(16'sd0, 16'hFFFF, 1'b1);
    send_coef(-16'sd32768, 16'h1234, 1'b0);
    send_coef(16'sd32767, 16'h8000, 1'b1);
    send_coef(16'sd1024, 16'd2047, 1'b0);
  endtask

  // Full 16-bit range, skip-zero, both directions
  task automatic test_full_range_skip_zero();
    set_config(-16'sd32768, 16'sd32767, 1'b0, 1'b1);
    send_coef(16'sd0, 16'h5555, 1'b0);
    send_coef(16'sd5, 16'hFFFB, 1'b0);       // would encrypt to zero: kept
    send_coef(-16'sd32768, 16'hFFFF, 1'b1);
    send_coef(16'sd32767, 16'h0001, 1'b0);
    set_config(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
    send_coef(16'sd0, 16'h1111, 1'b0);
    send_coef(-16'sd32768, 16'h0000, 1'b1);
    send_coef(16'sd1, 16'h0001, 1'b0);       // decrypt may yield zero
  endtask

  // One-value ranges
  task automatic test_single_value_range();
    set_config(16'sd7, 16'sd7, 1'b1, 1'b1);
    send_coef(16'sd0, 16'hABCD, 1'b1);       // zero still forced to min
    send_coef(-16'sd5, 16'h0000, 1'b0);
    set_config(16'sd7, 16'sd7, 1'b0, 1'b1);
    send_coef(16'sd0, 16'h0042, 1'b0);
    send_coef(16'sd100, 16'h0003, 1'b0);
    set_config(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_coef(16'sd9, 16'h0000, 1'b1);       // only value is zero: kept
  endtask

  // max below min: error flag and pass-through
  task automatic test_empty_range();
    set_config(16'sd100, -16'sd100, 1'b0, 1'b0);
    send_coef(16'sd50, 16'hFFFF, 1'b1);
    send_coef(-16'sd32768, 16'h0000, 1'b0);
    set_config(16'sd32767, -16'sd32768, 1'b1, 1'b1);
    send_coef(16'sd0, 16'h7777, 1'b0);
    send_coef(16'sd32767, 16'hFFFF, 1'b1);
  endtask

  // Random streams over many range shapes, every direction and skip combination
  task automatic test_random_streams();
    int kind;
    int sel;
    longint lo, hi, span, shift;
    mrsc_pkg::coef_t coef;
    logic [KW-1:0] ks;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = (phase < 9) ? phase : $urandom_range(0, 8);
      case (kind)
        0: begin lo = -32768; hi = 32767; end
        1: begin
          lo = -longint'($urandom_range(0, 20));
          hi = longint'($urandom_range(0, 20));
        end
        2: begin
          lo = longint'(mrsc_pkg::coef_t'($urandom));
          hi = longint'(mrsc_pkg::coef_t'($urandom));
          if (hi < lo) begin span = lo; lo = hi; hi = span; end
        end
        3: begin
          lo = ($urandom_range(0, 1) != 0) ? 64'sd0 : longint'(mrsc_pkg::coef_t'($urandom));
          hi = lo;
        end
        4: begin
          lo = longint'($urandom_range(1, 32767));
          hi = -longint'($urandom_range(0, 32768));
        end
        5: begin
          lo = longint'($urandom_range(1, 1000));
          hi = lo + longint'($urandom_range(0, 3000));
        end
        6: begin lo = 32767 - longint'($urandom_range(0, 300)); hi = 32767; end
        7: begin lo = -32768; hi = -32768 + longint'($urandom_range(0, 300)); end
        default: begin
          if ($urandom_range(0, 1) != 0) begin
            lo = 0;
            hi = longint'($urandom_range(1, 10));
          end else begin
            lo = -longint'($urandom_range(1, 10));
            hi = 0;
          end
        end
      endcase
      set_config(mrsc_pkg::coef_t'(lo), mrsc_pkg::coef_t'(hi), logic'(phase % 2),
                 logic'((phase / 2) % 2));
      span = hi - lo + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // one forced full pause mid-run, and the odd random one
        if ((phase == 5 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 299) == 0) begin
          drain_results();
        end
        sel = $urandom_range(0, 15);
        ks = (sel == 0) ? '0 : (sel == 1) ? '1 : KW'($urandom);
        sel = $urandom_range(0, 9);
        if (hi < lo || sel == 1) begin
          coef = mrsc_pkg::coef_t'($urandom);
        end else if (sel == 0) begin
          coef = '0;
        end else if (sel == 2) begin
          coef = ($urandom_range(0, 1) != 0) ? mrsc_pkg::coef_t'(lo) : mrsc_pkg::coef_t'(hi);
        end else begin
          coef = mrsc_pkg::coef_t'(lo + longint'($urandom_range(0, int'(span - 1))));
          // pick a keystream word that lands the ciphertext on zero when encrypting
          if (sel == 3 && lo <= 0 && hi >= 0) begin
            shift = ((-longint'(coef)) % span + span) % span;
            ks = KW'(shift + span *
                     longint'($urandom_range(0, int'((65535 - shift) / span))));
          end
        end
        send_coef(coef, ks, ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = mrsc_pkg::CFG_RANGE_MIN;
    cfg_data    = '0;
    in_valid    = 1'b0;
    coefficient = '0;
    keystream   = '0;
    last_in     = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_settings();
    test_full_range_skip_zero();
    test_single_value_range();
    test_empty_range();
    test_random_streams();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d coefficients sent under %0d range settings, %0d results checked",
             coefs_sent, settings_used, results_checked);
    $display("summary: %0d results under an empty range, %0d end-of-block marks",
             empty_range_hits, block_ends);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
